// ===== design/dual_tone_generator_with_swap_fade_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual tone generator
// Shared property wrappers, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_TONE_GENERATOR_WITH_SWAP_FADE_TOP_MACROS_SVH
`define DUAL_TONE_GENERATOR_WITH_SWAP_FADE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dtg_pkg.sv =====
// ----------------------------------------------------------------------------
// dtg_pkg
// Types, constants and the quarter-wave sine table of the dual tone generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtg_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 32;
  localparam int QTR_SIZE        = 1 << (SINE_TABLE_BITS - 2);
  localparam int FADE_FRAC_BITS  = 15;
  localparam int FADE_CNT_BITS   = 21;
  localparam int FADE_LEN_BITS   = 20;
  localparam int DIV_CNT_BITS    = $clog2(FADE_FRAC_BITS);

  localparam logic [15:0]              FADE_ONE      = 16'h8000;
  localparam logic [FADE_CNT_BITS-1:0] FADE_CNT_MAX  = '1;
  localparam logic [63:0]              Q30_ONE       = 64'd1 << 30;
  localparam logic [63:0]              TWO_PI_Q30    = 64'd6746518852;

  // Register reset values
  localparam logic [15:0]              VOLUME_RST    = 16'd32768;
  localparam logic                     SWAP_EN_RST   = 1'b0;
  localparam logic                     FADE_EN_RST   = 1'b1;
  localparam logic [FADE_LEN_BITS-1:0] FADE_LEN_RST  = 20'd4800;

  typedef enum logic [1:0] {
    REG_VOLUME_GAIN      = 2'd0,
    REG_SWAP_ENABLE      = 2'd1,
    REG_SWAP_FADE_ENABLE = 2'd2,
    REG_FADE_LENGTH      = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_WRITE
  } dtg_state_e;

  typedef enum logic [1:0] {
    FK_FULL,
    FK_ZERO,
    FK_DOWN,
    FK_UP
  } fade_kind_e;

  typedef enum logic [2:0] {
    MUL_GAIN  = 3'd0,
    MUL_LVL_L = 3'd1,
    MUL_LVL_R = 3'd2,
    MUL_OUT_L = 3'd3,
    MUL_OUT_R = 3'd4
  } mul_step_e;

  typedef struct packed {
    logic                      done;
    logic [FADE_FRAC_BITS-1:0] quot;
  } div_stat_t;

  typedef struct packed {
    logic        neg;
    logic [14:0] mag;
  } sine_sample_t;

  typedef logic [QTR_SIZE-1:0][14:0] sine_qtr_t;

  // Taylor series sine in Q2.30, rounded to a Q1.15 magnitude
  function automatic logic [14:0] sine_mag_calc(input logic [63:0] a);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] mag;
    x   = (a * TWO_PI_Q30) >> SINE_TABLE_BITS;
    x2  = (x * x) >> 30;
    t   = Q30_ONE - x2 / 64'd110;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    mag = (((x * t) >> 30) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return mag[14:0];
  endfunction

  function automatic sine_qtr_t build_sine_qtr();
    sine_qtr_t tab;
    for (int k = 0; k < QTR_SIZE; k++) begin
      tab[k] = sine_mag_calc(64'(k));
    end
    return tab;
  endfunction

  localparam sine_qtr_t   SINE_QTR  = build_sine_qtr();
  localparam logic [14:0] SINE_PEAK = sine_mag_calc(64'(QTR_SIZE));

  // Fold the full-turn index onto the quarter table
  function automatic sine_sample_t sine_lookup(input logic [SINE_TABLE_BITS-1:0] idx);
    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-3:0] r;
    logic [SINE_TABLE_BITS-2:0] a;
    sine_sample_t               s;
    quad  = idx[SINE_TABLE_BITS-1 -: 2];
    r     = idx[SINE_TABLE_BITS-3:0];
    a     = quad[0] ? ((SINE_TABLE_BITS-1)'(QTR_SIZE) - {1'b0, r}) : {1'b0, r};
    s.neg = quad[1];
    s.mag = a[SINE_TABLE_BITS-2] ? SINE_PEAK : SINE_QTR[a[SINE_TABLE_BITS-3:0]];
    return s;
  endfunction

  // Round the scaled magnitude, saturate and apply the sign
  function automatic logic [15:0] chan_sat(input logic [31:0] prod, input logic neg);
    logic [32:0] sum;
    logic [17:0] m;
    logic [15:0] res;
    sum = {1'b0, prod} + 33'd16384;
    m   = sum[32:15];
    if (neg) begin
      res = (m > 18'd32768) ? 16'h8000 : (16'd0 - m[15:0]);
    end else begin
      res = (m > 18'd32767) ? 16'h7FFF : m[15:0];
    end
    return res;
  endfunction

endpackage

// ===== design/dtg_fade_div.sv =====
// ----------------------------------------------------------------------------
// dtg_fade_div
// Restoring serial divider for the fade ramp: quot = floor(num * 2^15 / den),
// with num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtg_fade_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [dtg_pkg::FADE_LEN_BITS-1:0] num_i,
  input  logic [dtg_pkg::FADE_LEN_BITS-1:0] den_i,
  output dtg_pkg::div_stat_t                stat_o
);
  import dtg_pkg::*;

  logic                      busy_q;
  logic                      done_q;
  logic [DIV_CNT_BITS-1:0]   cnt_q;
  logic [FADE_LEN_BITS:0]    rem_q;
  logic [FADE_LEN_BITS:0]    rem_d;
  logic [FADE_LEN_BITS-1:0]  den_q;
  logic [FADE_FRAC_BITS-1:0] quot_q;
  logic [FADE_LEN_BITS:0]    rem_sh;
  logic                      fits;

  assign rem_sh = {rem_q[FADE_LEN_BITS-1:0], 1'b0};
  assign fits   = rem_sh >= {1'b0, den_q};
  assign rem_d  = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_BITS'(FADE_FRAC_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[FADE_FRAC_BITS-2:0], fits};
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.quot = quot_q;

endmodule

// ===== design/dual_tone_generator_with_swap_fade_top.sv =====
// ----------------------------------------------------------------------------
// Dual tone generator with swap fade
// Two phase-accumulator sine oscillators scaled by volume, fade ramp and
// per-channel level, with optional channel swap, directly or through a fade sequence.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                    Payload
// s_axis   in         s_axis_tvalid/s_axis_tready  tdata: steps, levels; tuser: swap req
// m_axis   out        m_axis_tvalid/m_axis_tready  tdata: stereo pair; tuser: flags
// cfg      in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// Outside a fade ramp a sample goes from the transfer through the multiply steps
// to the result; on a ramp the serial fade divider runs first. The five
// products share one 16x16 multiplier. The input is not ready until the
// result is loaded into the output register, which frees while it waits.
// Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dual_tone_generator_with_swap_fade_top_macros.svh"

module dual_tone_generator_with_swap_fade_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // lowest bit up: left_phase_step[31:0], right_phase_step[63:32],
  // left_level[79:64], right_level[95:80]
  input  logic [95:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,   // swap_request[0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // lowest bit up: left_out[15:0], right_out[31:16]
  output logic [31:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // swapped_now[0], fade_done[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);
  import dtg_pkg::*;

  // Configuration
  logic [15:0]              volume_q;
  logic                     swap_en_q;
  logic                     fade_en_q;
  logic [FADE_LEN_BITS-1:0] fade_len_q;

  // Oscillator and swap state
  logic [PHASE_BITS-1:0]    acc_l_q, acc_r_q;
  logic                     swap_flag_q, swap_flag_d;
  logic                     fade_active_q, fade_active_d;
  logic                     fading_out_q, fading_out_d;
  logic [FADE_CNT_BITS-1:0] fade_cnt_q, fade_cnt_d;

  // Sequencer
  dtg_state_e state_q, state_d;
  mul_step_e  step_q;
  logic       accept;
  logic       div_start;
  logic       out_load;
  div_stat_t  div_stat;

  // Per-sample working registers
  fade_kind_e   kind_d, kind_q;
  logic         use_swap_d, swapped_d, done_d;
  logic         use_swap_q, swapped_q, done_q;
  logic [FADE_CNT_BITS-1:0] len_ext;
  logic [15:0]  fade_q;
  logic [15:0]  lvl_l_q, lvl_r_q;
  sine_sample_t sin_l_q, sin_r_q;
  logic [15:0]  gain_q, h_l_q, h_r_q;
  logic [15:0]  samp_l_q, samp_r_q;

  logic [15:0]  mul_a, mul_b;
  logic [31:0]  mul_prod;

  // Output register
  logic         m_valid_q;
  logic [31:0]  m_data_q;
  logic [1:0]   m_user_q;

  assign accept      = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q   <= VOLUME_RST;
      swap_en_q  <= SWAP_EN_RST;
      fade_en_q  <= FADE_EN_RST;
      fade_len_q <= FADE_LEN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_VOLUME_GAIN:      volume_q   <= cfg_data_i[15:0];
        REG_SWAP_ENABLE:      swap_en_q  <= cfg_data_i[0];
        REG_SWAP_FADE_ENABLE: fade_en_q  <= cfg_data_i[0];
        REG_FADE_LENGTH:      fade_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Swap and fade decision for the incoming sample
  // --------------------------------------------------------------------------
  assign len_ext = (fade_len_q == '0) ? FADE_CNT_BITS'(1) : {1'b0, fade_len_q};

  always_comb begin
    swap_flag_d   = swap_flag_q;
    fade_active_d = fade_active_q;
    fading_out_d  = fading_out_q;
    fade_cnt_d    = fade_cnt_q;
    use_swap_d    = swap_flag_q;
    swapped_d     = 1'b0;
    done_d        = 1'b0;
    kind_d        = FK_FULL;

    if (!fade_active_q && swap_en_q && s_axis_tuser[0]) begin
      if (fade_en_q) begin
        fade_active_d = 1'b1;
        fading_out_d  = 1'b1;
        fade_cnt_d    = '0;
      end else begin
        swap_flag_d = ~swap_flag_q;
        swapped_d   = 1'b1;
      end
    end

    if (fade_active_d) begin
      if (fading_out_d) begin
        if (fade_cnt_d >= len_ext) begin
          // bottom of the ramp: toggle and use the new flag at once
          kind_d       = FK_ZERO;
          swap_flag_d  = ~swap_flag_d;
          use_swap_d   = swap_flag_d;
          swapped_d    = 1'b1;
          fading_out_d = 1'b0;
          fade_cnt_d   = '0;
        end else begin
          kind_d = FK_DOWN;
        end
      end else if (fade_cnt_d >= len_ext) begin
        kind_d        = FK_FULL;
        done_d        = 1'b1;
        fade_active_d = 1'b0;
      end else begin
        kind_d = FK_UP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_l_q       <= '0;
      acc_r_q       <= '0;
      swap_flag_q   <= 1'b0;
      fade_active_q <= 1'b0;
      fading_out_q  <= 1'b1;
      fade_cnt_q    <= '0;
    end else if (accept) begin
      acc_l_q       <= acc_l_q + s_axis_tdata[PHASE_BITS-1:0];
      acc_r_q       <= acc_r_q + s_axis_tdata[32 +: PHASE_BITS];
      swap_flag_q   <= swap_flag_d;
      fade_active_q <= fade_active_d;
      fading_out_q  <= fading_out_d;
      // count the sample while the fade runs, saturating
      if (fade_active_d && fade_cnt_d != FADE_CNT_MAX) begin
        fade_cnt_q <= fade_cnt_d + 1'b1;
      end else begin
        fade_cnt_q <= fade_cnt_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Fade divider
  // --------------------------------------------------------------------------
  dtg_fade_div u_fade_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (fade_cnt_d[FADE_LEN_BITS-1:0]),
    .den_i  (len_ext[FADE_LEN_BITS-1:0]),
    .stat_o (div_stat)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (kind_d inside {FK_DOWN, FK_UP}) ? ST_DIV : ST_MUL;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (step_q == MUL_OUT_R) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        div_start     = s_axis_tvalid && (kind_d inside {FK_DOWN, FK_UP});
      end
      ST_WRITE: out_load = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= MUL_GAIN;
    end else begin
      state_q <= state_d;
      if (state_q != ST_MUL) begin
        step_q <= MUL_GAIN;
      end else begin
        step_q <= mul_step_e'(step_q + 3'd1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sample capture, fade factor and shared multiplier
  // --------------------------------------------------------------------------
  always_comb begin
    case (step_q)
      MUL_GAIN:  begin mul_a = volume_q;              mul_b = fade_q;  end
      MUL_LVL_L: begin mul_a = gain_q;                mul_b = lvl_l_q; end
      MUL_LVL_R: begin mul_a = gain_q;                mul_b = lvl_r_q; end
      MUL_OUT_L: begin mul_a = {1'b0, sin_l_q.mag};   mul_b = h_l_q;   end
      MUL_OUT_R: begin mul_a = {1'b0, sin_r_q.mag};   mul_b = h_r_q;   end
      default:   begin mul_a = '0;                    mul_b = '0;      end
    endcase
  end

  assign mul_prod = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= kind_d;
      use_swap_q <= swap_en_q & use_swap_d;
      swapped_q  <= swapped_d;
      done_q     <= done_d;
      lvl_l_q    <= s_axis_tdata[79:64];
      lvl_r_q    <= s_axis_tdata[95:80];
      // sine of the phase before the advance
      sin_l_q    <= sine_lookup(acc_l_q[PHASE_BITS-1 -: SINE_TABLE_BITS]);
      sin_r_q    <= sine_lookup(acc_r_q[PHASE_BITS-1 -: SINE_TABLE_BITS]);
      fade_q     <= (kind_d == FK_ZERO) ? 16'd0 : FADE_ONE;
    end else if (state_q == ST_DIV && div_stat.done) begin
      fade_q <= (kind_q == FK_DOWN) ? (FADE_ONE - {1'b0, div_stat.quot})
                                    : {1'b0, div_stat.quot};
    end

    if (state_q == ST_MUL) begin
      case (step_q)
        MUL_GAIN:  gain_q   <= mul_prod[30:15];
        MUL_LVL_L: h_l_q    <= mul_prod[31:16];
        MUL_LVL_R: h_r_q    <= mul_prod[31:16];
        MUL_OUT_L: samp_l_q <= chan_sat(mul_prod, sin_l_q.neg);
        MUL_OUT_R: samp_r_q <= chan_sat(mul_prod, sin_r_q.neg);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= use_swap_q ? {samp_l_q, samp_r_q} : {samp_r_q, samp_l_q};
      m_user_q <= {done_q, swapped_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `DTG_ASSERT_NEXT(a_busy_after_xfer, accept, !s_axis_tready, "input ready right after a transfer")
  `DTG_ASSERT_SAME(a_div_in_div_state, div_stat.done, state_q == ST_DIV, "divider done outside DIV")
  `DTG_ASSERT_SAME(a_fade_range, state_q == ST_MUL, fade_q <= FADE_ONE, "fade factor above one")
  `DTG_ASSERT_SAME(a_flags_exclusive, m_valid_q, !(m_user_q[0] && m_user_q[1]), "swap and fade end together")

endmodule
